FILE: rtl/core/amh_pkg.sv
// ----------------------------------------------------------------------------
// amh_pkg: shared types and codes for the addressable min-heap
// command and status codes, word structs and front-to-back request struct
// ----------------------------------------------------------------------------
package amh_pkg;

	localparam int IdBits      = 8;
	localparam int KeyBits     = 32;
	localparam int PayBits     = 32;
	localparam int PosBits     = 9;
	localparam int LimBits     = 9;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_SETKEY = 2'd1;
	localparam logic [1:0] CMD_DELMIN = 2'd2;
	localparam logic [1:0] CMD_REMOVE = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_DUP      = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	typedef struct packed {
		logic [1:0]                cmd;
		logic [IdBits-1:0]         entry_id;
		logic signed [KeyBits-1:0] entry_key;
		logic [PayBits-1:0]        entry_payload;
	} in_word_t;

	typedef struct packed {
		logic [2:0]                status;
		logic [IdBits-1:0]         out_id;
		logic signed [KeyBits-1:0] out_key;
		logic [PayBits-1:0]        out_payload;
	} out_word_t;

	// request handed from front to back
	typedef struct packed {
		in_word_t word;
	} req_t;

endpackage

FILE: rtl/core/amh_front.sv
// ----------------------------------------------------------------------------
// amh_front: input stage
// registers accepted words into a two-entry queue toward the back end
// ----------------------------------------------------------------------------
module amh_front (
	input  logic              clk,
	input  logic              arst_n,
	input  amh_pkg::in_word_t in_word,
	input  logic              in_valid,
	output logic              in_stall,
	output amh_pkg::req_t     req,
	output logic              req_valid,
	input  logic              req_take
);
	import amh_pkg::*;

	req_t       q_q [2];
	logic [1:0] cnt_q;
	logic       rd_q;
	logic       push, pop;

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign pop       = req_take && (cnt_q != 2'd0);
	assign req_valid = (cnt_q != 2'd0);
	assign req       = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 1'b0;
		end else begin
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_q[rd_q ^ cnt_q[0]].word <= in_word;
	end

endmodule

FILE: rtl/core/amh_back.sv
// ----------------------------------------------------------------------------
// amh_back: heap engine
// sequencer over the slot memory and position table, one slot-memory access per cycle
// ----------------------------------------------------------------------------
module amh_back #(
	parameter int Capacity = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [8:0]         lim,
	input  amh_pkg::req_t      req,
	input  logic               req_valid,
	output logic               req_take,
	output amh_pkg::out_word_t out_word,
	output logic               out_valid,
	input  logic               out_stall
);
	import amh_pkg::*;

	localparam int SlotBits = $clog2(Capacity + 1);
	localparam int MemBits  = $clog2(Capacity);
	localparam int Ids      = 1 << IdBits;

	localparam logic [3:0] S_IDLE = 4'd0, S_POS = 4'd1, S_DEC = 4'd2, S_RD = 4'd3,
		S_UPRD = 4'd4, S_UPCMP = 4'd5, S_DNRD = 4'd6, S_DNRD2 = 4'd7,
		S_DNCMP = 4'd8, S_PUT = 4'd9, S_OUT = 4'd10, S_LAST = 4'd11, S_LASTW = 4'd12;

	typedef struct packed {
		logic signed [KeyBits-1:0] k;
		logic [IdBits-1:0]         id;
		logic [PayBits-1:0]        pay;
	} ent_t;

	ent_t                slot_mem [Capacity];
	logic [SlotBits-1:0] pos_mem  [Ids];
	logic [Ids-1:0]      pos_vld_q;

	logic [3:0]          st_q;
	logic [SlotBits-1:0] cnt_q, p_q, c_q, pos_rd_q;
	ent_t                cur_q, rd_q, a_q, ret_q;
	in_word_t            w_q;
	logic                moved_q, upfirst_q;
	out_word_t           res_q, out_q;
	logic                ovld_q;

	// memory port controls
	logic                mwe, mre, pwe;
	logic [SlotBits-1:0] maddr, mraddr, pval;
	logic [MemBits-1:0]  widx, ridx;
	ent_t                mwd;
	logic [IdBits-1:0]   paddr_w;
	logic                dn_pick2;
	logic                out_go;

	// slots are 1-based, the memory is 0-based
	assign widx = MemBits'(maddr - SlotBits'(1));
	assign ridx = MemBits'(mraddr - SlotBits'(1));

	always_ff @(posedge clk) begin
		if (mwe) slot_mem[widx] <= mwd;
		if (mre) rd_q <= slot_mem[ridx];
		if (pwe) pos_mem[paddr_w] <= pval;
		pos_rd_q <= pos_vld_q[req.word.entry_id] ? pos_mem[req.word.entry_id] : '0;
	end

	logic [SlotBits-1:0] lim_eff;
	assign lim_eff = ({23'd0, lim} > 32'(Capacity)) ? SlotBits'(Capacity) : SlotBits'(lim);

	// right child wins only when present and strictly smaller
	assign dn_pick2  = (c_q != '0) && (c_q < cnt_q) && (rd_q.k < a_q.k);
	// result register frees up when empty or drained this cycle
	assign out_go    = (st_q == S_OUT) && (!ovld_q || !out_stall);

	assign req_take  = (st_q == S_IDLE) && req_valid;
	assign out_word  = out_q;
	assign out_valid = ovld_q;

	always_comb begin
		mwe = 1'b0; mre = 1'b0; pwe = 1'b0;
		maddr = p_q; mraddr = p_q; mwd = cur_q;
		paddr_w = cur_q.id; pval = p_q;
		case (st_q)
			S_POS: begin
				mre = 1'b1;
				mraddr = (w_q.cmd == CMD_DELMIN) ? SlotBits'(1) : pos_rd_q;
			end
			S_DEC: begin mre = 1'b1; mraddr = cnt_q; end
			S_UPRD: begin mre = 1'b1; mraddr = p_q >> 1; end
			S_UPCMP: if (p_q > 1 && cur_q.k < rd_q.k) begin
				mwe = 1'b1; mwd = rd_q; pwe = 1'b1; paddr_w = rd_q.id;
			end
			S_DNRD: begin mre = 1'b1; mraddr = p_q << 1; end
			S_DNRD2: begin mre = 1'b1; mraddr = (p_q << 1) + 1'b1; end
			S_DNCMP: if (c_q != '0 && !dn_pick2 && a_q.k < cur_q.k) begin
				mwe = 1'b1; mwd = a_q; pwe = 1'b1; paddr_w = a_q.id;
			end
			S_PUT: begin mwe = 1'b1; pwe = 1'b1; end
			S_LASTW: begin pwe = 1'b1; paddr_w = ret_q.id; pval = '0; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; cnt_q <= '0; ovld_q <= 1'b0; pos_vld_q <= '0;
			moved_q <= 1'b0; upfirst_q <= 1'b0;
		end else begin
			if (out_go) ovld_q <= 1'b1;
			else if (!out_stall) ovld_q <= 1'b0;
			if (pwe) pos_vld_q[paddr_w] <= (pval != '0);
			case (st_q)
				S_IDLE: if (req_take) begin
					w_q <= req.word; res_q <= '0; moved_q <= 1'b0; st_q <= S_POS;
				end
				S_POS: begin
					case (w_q.cmd)
						CMD_INSERT:
							if (cnt_q >= lim_eff) begin res_q.status <= ST_FULL; st_q <= S_OUT; end
							else if (pos_rd_q != '0) begin res_q.status <= ST_DUP; st_q <= S_OUT; end
							else begin
								cnt_q <= cnt_q + 1'b1; p_q <= cnt_q + 1'b1;
								cur_q <= '{w_q.entry_key, w_q.entry_id, w_q.entry_payload};
								st_q <= S_UPRD;
							end
						CMD_DELMIN:
							if (cnt_q == '0) begin res_q.status <= ST_EMPTY; st_q <= S_OUT; end
							else begin p_q <= SlotBits'(1); st_q <= S_RD; end
						default:
							if (pos_rd_q == '0) begin res_q.status <= ST_NOTFOUND; st_q <= S_OUT; end
							else begin p_q <= pos_rd_q; st_q <= S_RD; end
					endcase
				end
				S_RD: begin
					if (w_q.cmd == CMD_SETKEY) begin
						cur_q <= '{w_q.entry_key, rd_q.id, rd_q.pay};
						if (rd_q.k < w_q.entry_key) st_q <= S_DNRD;
						else if (w_q.entry_key < rd_q.k) st_q <= S_UPRD;
						else st_q <= S_OUT;
					end else begin
						ret_q <= rd_q;
						res_q.out_key <= rd_q.k; res_q.out_payload <= rd_q.pay;
						if (w_q.cmd == CMD_DELMIN) res_q.out_id <= rd_q.id;
						st_q <= S_DEC;
					end
				end
				S_DEC: st_q <= S_LAST;
				S_LAST: begin
					cnt_q <= cnt_q - 1'b1;
					cur_q <= rd_q;
					st_q <= S_LASTW;
				end
				S_LASTW: begin
					// last slot refills the hole unless the hole was the last slot
					if (p_q > cnt_q) st_q <= S_OUT;
					else begin upfirst_q <= 1'b1; st_q <= S_UPRD; end
				end
				S_UPRD: st_q <= S_UPCMP;
				S_UPCMP: begin
					if (p_q > 1 && cur_q.k < rd_q.k) begin
						p_q <= p_q >> 1; moved_q <= 1'b1; st_q <= S_UPRD;
					end else if (upfirst_q && !moved_q) begin
						upfirst_q <= 1'b0; st_q <= S_DNRD;
					end else begin
						upfirst_q <= 1'b0; st_q <= S_PUT;
					end
				end
				S_DNRD: begin
					// no child when 2p exceeds the count
					if (p_q > (cnt_q >> 1)) begin c_q <= '0; st_q <= S_DNCMP; end
					else st_q <= S_DNRD2;
				end
				S_DNRD2: begin
					a_q <= rd_q; c_q <= p_q << 1;
					st_q <= S_DNCMP;
				end
				S_DNCMP: begin
					// second child read lands here when present
					if (dn_pick2) begin
						a_q <= rd_q; c_q <= c_q + 1'b1;
						st_q <= S_DNCMP;
					end else if (c_q != '0 && a_q.k < cur_q.k) begin
						p_q <= c_q; c_q <= '0; st_q <= S_DNRD;
					end else st_q <= S_PUT;
				end
				S_PUT: st_q <= S_OUT;
				S_OUT: if (out_go) begin out_q <= res_q; st_q <= S_IDLE; end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/core/addressable_min_heap.sv
// ----------------------------------------------------------------------------
// addressable_min_heap: indexed binary min-heap with id lookup
// insert, set key, delete minimum and remove by id over a slot memory
// ----------------------------------------------------------------------------
// Commands enter a two-word queue at the front and are executed one at a
// time by the back end, which walks the heap one slot-memory access per cycle.
// The time a command takes grows with the number of heap levels it sifts.
// A finished result sits in its own output register, so the next command
// may start while it waits; only a second result waits on the receiver.
// The id table is cleared at reset by per-id valid bits. capacity_limit
// sits at address 0 and is read back on prdata.
module addressable_min_heap #(
	parameter int CAPACITY = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  amh_pkg::in_word_t  in_word,
	input  logic               in_valid,
	output logic               in_stall,
	output amh_pkg::out_word_t out_word,
	output logic               out_valid,
	input  logic               out_stall,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import amh_pkg::*;

	logic [LimBits-1:0] lim_q;
	req_t               req;
	logic               req_valid, req_take;

	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? {{(32-LimBits){1'b0}}, lim_q} : 32'd0;

	// capacity register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lim_q <= 9'd256;
		else if (psel && penable && pwrite && paddr == 3'd0) lim_q <= pwdata[LimBits-1:0];
	end

	amh_front u_front (
		.clk, .arst_n, .in_word, .in_valid, .in_stall,
		.req, .req_valid, .req_take
	);

	amh_back #(.Capacity(CAPACITY)) u_back (
		.clk, .arst_n, .lim(lim_q), .req, .req_valid, .req_take,
		.out_word, .out_valid, .out_stall
	);

endmodule

FILE: rtl/core/amh_checker.sv
// ----------------------------------------------------------------------------
// amh_checker: port-level checks for the heap
// protocol and status sanity seen from the ports
// ----------------------------------------------------------------------------
module amh_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input amh_pkg::out_word_t out_word,
	input logic               pready
);
	import amh_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word)) else $error("word dropped");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.status <= ST_EMPTY) else $error("bad status");
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status != ST_OK |-> out_word.out_key == '0)
		else $error("failed word carries data");
	a_rdy: assert property (@(posedge clk) pready) else $error("pready low");

endmodule

bind addressable_min_heap amh_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .out_word, .pready
);
